// File: rtl/alpha_blit_compositor_top_defines.svh
`ifndef ALPHA_BLIT_COMPOSITOR_TOP_DEFINES_SVH
`define ALPHA_BLIT_COMPOSITOR_TOP_DEFINES_SVH

// same-cycle implication, checked on the rising edge of i_clk outside reset
`define ABC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ABC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/abc_pkg.sv
package abc_pkg;

    localparam int unsigned CH_W        = 8;
    localparam int unsigned NUM_CH      = 4;
    localparam int unsigned NUM_COLOR   = 3;
    localparam int unsigned ALPHA_CH    = 3;
    localparam int unsigned CFG_W       = 15;
    localparam int unsigned OFS_W       = 16;
    localparam int unsigned POS_W       = OFS_W + 1;
    localparam int unsigned ADDR_W      = 28;
    localparam int unsigned BASE_W      = 2 * CH_W;
    localparam int unsigned BLD_W       = 2 * CH_W + 1;
    localparam int unsigned APB_DW      = 32;
    localparam int unsigned APB_AW      = 5;
    localparam int unsigned IN_TDATA_W  = 64;
    localparam int unsigned OUT_TDATA_W = 64;
    localparam int unsigned TUSER_W     = 2;
    localparam int unsigned TUSER_WE    = 0;
    localparam int unsigned TUSER_IN    = 1;
    localparam int unsigned MAX_DIM_DEF = 16384;

    localparam logic [CH_W-1:0]   ALPHA_CLEAR  = 8'd0;
    localparam logic [CH_W-1:0]   ALPHA_OPAQUE = 8'd255;
    localparam logic [BASE_W-1:0] ROUND_BIAS   = 16'd127;

    typedef enum logic [2:0] {
        REG_SRC_WIDTH  = 3'd0,
        REG_SRC_HEIGHT = 3'd1,
        REG_DST_WIDTH  = 3'd2,
        REG_DST_HEIGHT = 3'd3,
        REG_OFFSET_X   = 3'd4,
        REG_OFFSET_Y   = 3'd5
    } t_reg_idx;

    // sizes already clamped to 1..MAX_DIM, offsets as two's complement bits
    typedef struct packed {
        logic [CFG_W-1:0] src_width;
        logic [CFG_W-1:0] src_height;
        logic [CFG_W-1:0] dst_width;
        logic [CFG_W-1:0] dst_height;
        logic [OFS_W-1:0] offset_x;
        logic [OFS_W-1:0] offset_y;
    } t_cfg;

endpackage

// File: rtl/abc_regs.sv
module abc_regs #(
    parameter int unsigned MAX_DIM = abc_pkg::MAX_DIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [abc_pkg::APB_AW-1:0]  paddr,
    input  logic [abc_pkg::APB_DW-1:0]  pwdata,
    output logic [abc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output abc_pkg::t_cfg               o_cfg
);
    import abc_pkg::*;

    localparam logic [CFG_W-1:0] DIM_MAX = CFG_W'(MAX_DIM);

    logic [CFG_W-1:0] r_src_width;
    logic [CFG_W-1:0] r_src_height;
    logic [CFG_W-1:0] r_dst_width;
    logic [CFG_W-1:0] r_dst_height;
    logic [OFS_W-1:0] r_offset_x;
    logic [OFS_W-1:0] r_offset_y;

    t_reg_idx reg_idx;
    logic     wr_en;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > DIM_MAX) begin
            res = DIM_MAX;
        end
        return res;
    endfunction

    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= CFG_W'(1);
            r_src_height <= CFG_W'(1);
            r_dst_width  <= CFG_W'(1);
            r_dst_height <= CFG_W'(1);
            r_offset_x   <= '0;
            r_offset_y   <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SRC_WIDTH:  r_src_width  <= pwdata[CFG_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= pwdata[CFG_W-1:0];
                REG_DST_WIDTH:  r_dst_width  <= pwdata[CFG_W-1:0];
                REG_DST_HEIGHT: r_dst_height <= pwdata[CFG_W-1:0];
                REG_OFFSET_X:   r_offset_x   <= pwdata[OFS_W-1:0];
                REG_OFFSET_Y:   r_offset_y   <= pwdata[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SRC_WIDTH:  prdata = APB_DW'(r_src_width);
            REG_SRC_HEIGHT: prdata = APB_DW'(r_src_height);
            REG_DST_WIDTH:  prdata = APB_DW'(r_dst_width);
            REG_DST_HEIGHT: prdata = APB_DW'(r_dst_height);
            REG_OFFSET_X:   prdata = APB_DW'(r_offset_x);
            REG_OFFSET_Y:   prdata = APB_DW'(r_offset_y);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.src_width  = clamp_dim(r_src_width);
    assign o_cfg.src_height = clamp_dim(r_src_height);
    assign o_cfg.dst_width  = clamp_dim(r_dst_width);
    assign o_cfg.dst_height = clamp_dim(r_dst_height);
    assign o_cfg.offset_x   = r_offset_x;
    assign o_cfg.offset_y   = r_offset_y;

endmodule

// File: rtl/alpha_blit_compositor_top.sv
// Source-over sprite blitter. Each input transaction carries one sprite pixel in raster
// order together with the destination pixel at its target position; the block tracks the
// sprite column and row, adds the signed offsets, clips against the destination size and
// returns the pixel to write back, a write enable, an inside flag, the linear destination
// address (row * dst_width + column, zero when clipped) and tlast on the final sprite pixel.
// A partial alpha gives (s*a + d*(255-a) + 127)/255 per colour and alpha 255; alpha 255
// copies the source, alpha 0 keeps the destination. Sizes of 0 act as 1 and sizes above
// MAX_DIM act as MAX_DIM. Registers sit on the APB port at byte addresses 0x00 src_width,
// 0x04 src_height, 0x08 dst_width, 0x0c dst_height, 0x10 offset_x, 0x14 offset_y; the user
// must write them only between sprites; the block does not enforce it. The block takes one
// pixel per clock cycle unless m_axis_tready holds back the output register. The input
// register feeds the clipping, the per-colour 9x8 blend multipliers, the divide by 255 and
// the row-times-width address multiplier; the output register holds the result until taken.
`include "alpha_blit_compositor_top_defines.svh"

module alpha_blit_compositor_top #(
    parameter int unsigned MAX_DIM = abc_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
    input  logic [abc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_red, out_green, out_blue, out_alpha, dst_address, 4 zero bits
    output logic [abc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // write_enable, inside_bounds
    output logic [abc_pkg::TUSER_W-1:0]      m_axis_tuser,
    output logic                             m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [abc_pkg::APB_AW-1:0]       paddr,
    input  logic [abc_pkg::APB_DW-1:0]       pwdata,
    output logic [abc_pkg::APB_DW-1:0]       prdata,
    output logic                             pready
);
    import abc_pkg::*;

    localparam int unsigned CNT_W  = $clog2(MAX_DIM);
    localparam int unsigned CW1    = CNT_W + 1;
    localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
    localparam int unsigned PROD_W = CNT_W + DIM_W;
    localparam int unsigned SUM_W  = (PROD_W > ADDR_W) ? PROD_W : ADDR_W;
    localparam int unsigned PAD_W  = OUT_TDATA_W - ADDR_W - NUM_CH * CH_W;

    t_cfg cfg;

    abc_regs #(
        .MAX_DIM (MAX_DIM)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [DIM_W-1:0] src_w, src_h, dst_w, dst_h;

    assign src_w = cfg.src_width[DIM_W-1:0];
    assign src_h = cfg.src_height[DIM_W-1:0];
    assign dst_w = cfg.dst_width[DIM_W-1:0];
    assign dst_h = cfg.dst_height[DIM_W-1:0];

    // pipeline handshake: each stage loads when empty or when draining forward
    logic r_v1, r_vo;
    logic ld_out, ld1, in_fire;

    assign ld_out        = !r_vo || m_axis_tready;
    assign ld1           = !r_v1 || ld_out;
    assign s_axis_tready = ld1 && i_rst_n;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // sprite position counters
    logic [CNT_W-1:0] r_col, r_row, n_col, n_row;
    logic [CW1-1:0]   col_inc, row_inc;
    logic             end_row, end_all;

    assign col_inc = CW1'(r_col) + CW1'(1);
    assign row_inc = CW1'(r_row) + CW1'(1);
    assign end_row = col_inc >= CW1'(src_w);
    assign end_all = end_row && (row_inc >= CW1'(src_h));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_fire) begin
            if (end_row) begin
                n_col = '0;
                n_row = end_all ? '0 : row_inc[CNT_W-1:0];
            end else begin
                n_col = col_inc[CNT_W-1:0];
            end
        end
    end

    logic [POS_W-1:0] ox_in, oy_in;

    assign ox_in = {cfg.offset_x[OFS_W-1], cfg.offset_x} + POS_W'(r_col);
    assign oy_in = {cfg.offset_y[OFS_W-1], cfg.offset_y} + POS_W'(r_row);

    // stage 1: captured transaction and target position
    logic [NUM_CH-1:0][CH_W-1:0] r_src1, r_dst1;
    logic [POS_W-1:0]            r_ox1, r_oy1;
    logic                        r_last1;

    logic                              inside1;
    logic [PROD_W-1:0]                 row_prod;
    logic [NUM_COLOR-1:0][BLD_W-1:0]   blend_prod;
    logic [NUM_COLOR-1:0][BASE_W-1:0]  blend_base;

    assign inside1 = !r_ox1[POS_W-1] && !r_oy1[POS_W-1]
                     && (r_ox1 < POS_W'(dst_w)) && (r_oy1 < POS_W'(dst_h));
    assign row_prod = PROD_W'(r_oy1[CNT_W-1:0]) * PROD_W'(dst_w);

    // s*a + d*(255-a) + 127 is split as (s-d)*a plus d*255 + 127
    always_comb begin
        logic [CH_W:0]             diff;
        logic signed [BLD_W-1:0]   diff_ext;
        logic signed [BLD_W-1:0]   alpha_ext;
        for (int c = 0; c < NUM_COLOR; c++) begin
            diff          = {1'b0, r_src1[c]} - {1'b0, r_dst1[c]};
            diff_ext      = BLD_W'($signed(diff));
            alpha_ext     = BLD_W'({1'b0, r_src1[ALPHA_CH]});
            blend_prod[c] = diff_ext * alpha_ext;
            blend_base[c] = (BASE_W'(r_dst1[c]) << CH_W) - BASE_W'(r_dst1[c]) + ROUND_BIAS;
        end
    end

    logic [NUM_CH-1:0][CH_W-1:0]    px1;
    logic [NUM_COLOR-1:0][CH_W-1:0] blend_px;
    logic [SUM_W-1:0]               addr_sum;
    logic [ADDR_W-1:0]              addr1;
    logic                           we1;

    // divide by 255 as (x + 1 + (x >> 8)) >> 8, exact over the blend range
    always_comb begin
        logic [BLD_W-1:0]  x;
        logic [BASE_W-1:0] xs;
        logic [BLD_W-1:0]  q;
        for (int c = 0; c < NUM_COLOR; c++) begin
            x           = BLD_W'(blend_base[c]) + blend_prod[c];
            xs          = x[BASE_W-1:0];
            q           = (BLD_W'(xs) + BLD_W'(1) + BLD_W'(xs >> CH_W)) >> CH_W;
            blend_px[c] = q[CH_W-1:0];
        end
    end

    assign addr_sum = SUM_W'(row_prod) + SUM_W'(r_ox1[CNT_W-1:0]);
    assign addr1    = inside1 ? addr_sum[ADDR_W-1:0] : '0;
    assign we1      = inside1 && (r_src1[ALPHA_CH] != ALPHA_CLEAR);

    always_comb begin
        px1 = r_dst1;
        if (we1) begin
            if (r_src1[ALPHA_CH] == ALPHA_OPAQUE) begin
                px1 = r_src1;
            end else begin
                for (int c = 0; c < NUM_COLOR; c++) begin
                    px1[c] = blend_px[c];
                end
                px1[ALPHA_CH] = ALPHA_OPAQUE;
            end
        end
    end

    // output register
    logic [NUM_CH-1:0][CH_W-1:0] r_opx;
    logic [ADDR_W-1:0]           r_oaddr;
    logic                        r_owe, r_oin, r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_vo  <= 1'b0;
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (ld1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (ld_out) begin
                r_vo <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_src1  <= s_axis_tdata[NUM_CH*CH_W-1:0];
            r_dst1  <= s_axis_tdata[2*NUM_CH*CH_W-1:NUM_CH*CH_W];
            r_ox1   <= ox_in;
            r_oy1   <= oy_in;
            r_last1 <= end_all;
        end
        if (ld_out) begin
            r_opx   <= px1;
            r_oaddr <= addr1;
            r_owe   <= we1;
            r_oin   <= inside1;
            r_olast <= r_last1;
        end
    end

    assign m_axis_tvalid          = r_vo;
    assign m_axis_tdata           = {{PAD_W{1'b0}}, r_oaddr, r_opx};
    assign m_axis_tuser[TUSER_WE] = r_owe;
    assign m_axis_tuser[TUSER_IN] = r_oin;
    assign m_axis_tlast           = r_olast;

    `ABC_ASSERT_SAME(a_we_inside, m_axis_tvalid && r_owe, r_oin, "write enable on a clipped pixel")
    `ABC_ASSERT_SAME(a_clip_addr, m_axis_tvalid && !r_oin, r_oaddr == '0, "clipped pixel with address")
    `ABC_ASSERT_SAME(a_we_alpha, m_axis_tvalid && r_owe, r_opx[ALPHA_CH] == ALPHA_OPAQUE, "written alpha not opaque")
    `ABC_ASSERT_NEXT(a_wrap, in_fire && end_all, (r_col == '0) && (r_row == '0), "counters did not wrap")

endmodule

// File: bench/tb_alpha_blit_compositor_top.sv
module tb_alpha_blit_compositor_top;
    import abc_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 60;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [CH_W-1:0]   alpha;
        logic              write_en;
        logic              in_bounds;
        logic [ADDR_W-1:0] address;
        logic              last;
    } t_blit_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // out_red, out_green, out_blue, out_alpha, dst_address, 4 zero bits
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // write_enable, inside_bounds
    logic [TUSER_W-1:0]     m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    alpha_blit_compositor_top i_dut (.*);

    // predictor copy of the registers and the sprite position
    logic [CFG_W-1:0] sprite_w_reg, sprite_h_reg, canvas_w_reg, canvas_h_reg;
    logic [OFS_W-1:0] shift_x_reg, shift_y_reg;
    int unsigned      sprite_col, sprite_row;

    logic [IN_TDATA_W-1:0] pixel_queue[$];
    t_blit_result          expected_pixels[$];
    int                    pixels_queued = 0;
    int                    results_seen = 0;
    int                    error_count = 0;
    int                    stall_cycles = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    calm_left = 0;
    logic                  in_taken = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(v);
    endfunction

    function automatic logic [CH_W-1:0] blend_channel(int s, int d, int a);
        return CH_W'((s * a + d * (255 - a) + 127) / 255);
    endfunction

    task automatic predict_composite(input logic [IN_TDATA_W-1:0] px);
        int unsigned  sw, sh, dw, dh;
        int           tx, ty;
        int           a;
        logic         row_done;
        t_blit_result r;
        sw = clamp_size(sprite_w_reg);
        sh = clamp_size(sprite_h_reg);
        dw = clamp_size(canvas_w_reg);
        dh = clamp_size(canvas_h_reg);
        tx = int'($signed(shift_x_reg)) + int'(sprite_col);
        ty = int'($signed(shift_y_reg)) + int'(sprite_row);
        a  = px[31:24];
        // default: destination pixel passes through
        r.red       = px[39:32];
        r.green     = px[47:40];
        r.blue      = px[55:48];
        r.alpha     = px[63:56];
        r.in_bounds = tx >= 0 && ty >= 0 && tx < int'(dw) && ty < int'(dh);
        r.write_en  = r.in_bounds && a != 0;
        r.address   = '0;
        if (r.in_bounds) begin
            r.address = ADDR_W'(ty * int'(dw) + tx);
            if (px[31:24] == ALPHA_OPAQUE) begin
                r.red   = px[7:0];
                r.green = px[15:8];
                r.blue  = px[23:16];
                r.alpha = px[31:24];
            end else if (px[31:24] != ALPHA_CLEAR) begin
                r.red   = blend_channel(px[7:0], px[39:32], a);
                r.green = blend_channel(px[15:8], px[47:40], a);
                r.blue  = blend_channel(px[23:16], px[55:48], a);
                r.alpha = ALPHA_OPAQUE;
            end
        end
        row_done = sprite_col + 1 >= sw;
        r.last   = row_done && sprite_row + 1 >= sh;
        expected_pixels.push_back(r);
        if (row_done) begin
            sprite_col = 0;
            sprite_row = r.last ? 0 : sprite_row + 1;
        end else begin
            sprite_col = sprite_col + 1;
        end
    endtask

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    // driver: one pixel transaction per handshake, idling at random
    always @(negedge i_clk) begin
        if (calm_left > 0) begin
            calm_left <= calm_left - 1;
        end else if ($urandom_range(99) < 2) begin
            calm_left <= $urandom_range(40, 10);
        end
        if (!s_axis_tvalid || in_taken) begin
            if (pixel_queue.size() != 0 &&
                (calm_left > 0 || $urandom_range(99) >= send_idle_pct)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pixel_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= calm_left > 0 || $urandom_range(99) >= recv_stall_pct;
    end

    // monitor: predicts on input transactions, checks output transactions
    always @(posedge i_clk) begin : monitor
        t_blit_result got, want;
        if (i_rst_n) begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got.red       = m_axis_tdata[7:0];
                got.green     = m_axis_tdata[15:8];
                got.blue      = m_axis_tdata[23:16];
                got.alpha     = m_axis_tdata[31:24];
                got.address   = m_axis_tdata[32 +: ADDR_W];
                got.write_en  = m_axis_tuser[TUSER_WE];
                got.in_bounds = m_axis_tuser[TUSER_IN];
                got.last      = m_axis_tlast;
                if (expected_pixels.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", got));
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.red !== want.red)
                        report_mismatch($sformatf("red %h, want %h", got.red, want.red));
                    if (got.green !== want.green)
                        report_mismatch($sformatf("green %h, want %h", got.green, want.green));
                    if (got.blue !== want.blue)
                        report_mismatch($sformatf("blue %h, want %h", got.blue, want.blue));
                    if (got.alpha !== want.alpha)
                        report_mismatch($sformatf("alpha %h, want %h", got.alpha, want.alpha));
                    if (got.write_en !== want.write_en)
                        report_mismatch($sformatf("write enable %b, want %b",
                                                  got.write_en, want.write_en));
                    if (got.in_bounds !== want.in_bounds)
                        report_mismatch($sformatf("inside %b, want %b",
                                                  got.in_bounds, want.in_bounds));
                    if (got.address !== want.address)
                        report_mismatch($sformatf("address %h, want %h",
                                                  got.address, want.address));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
                end
                results_seen <= results_seen + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_composite(s_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic write_blit_reg(input t_reg_idx idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  sprite_w_reg = value[CFG_W-1:0];
            REG_SRC_HEIGHT: sprite_h_reg = value[CFG_W-1:0];
            REG_DST_WIDTH:  canvas_w_reg = value[CFG_W-1:0];
            REG_DST_HEIGHT: canvas_h_reg = value[CFG_W-1:0];
            REG_OFFSET_X:   shift_x_reg  = value[OFS_W-1:0];
            REG_OFFSET_Y:   shift_y_reg  = value[OFS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_blit(input logic [APB_DW-1:0] sw, sh, dw, dh, ox, oy);
        write_blit_reg(REG_SRC_WIDTH, sw);
        write_blit_reg(REG_SRC_HEIGHT, sh);
        write_blit_reg(REG_DST_WIDTH, dw);
        write_blit_reg(REG_DST_HEIGHT, dh);
        write_blit_reg(REG_OFFSET_X, ox);
        write_blit_reg(REG_OFFSET_Y, oy);
    endtask

    function automatic logic [APB_DW-1:0] random_size(int unsigned typical);
        logic [APB_DW-1:0] v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = $urandom_range(32767, MAX_DIM_DEF);
            2:       v = $urandom_range(32767);
            default: v = $urandom_range(typical, 1);
        endcase
        // bits above the register width are ignored
        if ($urandom_range(3) == 0) v[APB_DW-1:CFG_W] = (APB_DW-CFG_W)'($urandom);
        return v;
    endfunction

    function automatic logic [APB_DW-1:0] random_offset();
        if ($urandom_range(3) == 0) return $urandom;
        return $urandom_range(24) - 8;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_pixel(
        input logic [CH_W-1:0] sr, sg, sb, sa, dr, dg, db, da);
        return {da, db, dg, dr, sa, sb, sg, sr};
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_pixel();
        logic [CH_W-1:0] a;
        case ($urandom_range(9))
            0, 1:    a = ALPHA_CLEAR;
            2, 3:    a = ALPHA_OPAQUE;
            4:       a = $urandom_range(1) ? 8'd1 : 8'd254;
            default: a = CH_W'($urandom_range(255));
        endcase
        return {32'($urandom), a, 24'($urandom)};
    endfunction

    task automatic queue_pixel(input logic [IN_TDATA_W-1:0] px);
        pixel_queue.push_back(px);
        pixels_queued++;
    endtask

    task automatic wait_for_drain();
        while (results_seen < pixels_queued || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [CH_W-1:0] dir_alpha[12];
        int              mode_send[4];
        int              mode_recv[4];
        dir_alpha = '{8'd255, 8'd0, 8'd255, 8'd1, 8'd254, 8'd128,
                      8'd128, 8'd1, 8'd254, 8'd255, 8'd0, 8'd77};
        mode_send = '{0, 88, 0, 31};
        mode_recv = '{0, 0, 88, 31};
        sprite_w_reg = 1;
        sprite_h_reg = 1;
        canvas_w_reg = 1;
        canvas_h_reg = 1;
        shift_x_reg  = '0;
        shift_y_reg  = '0;
        sprite_col   = 0;
        sprite_row   = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset layout: one pixel sprite on a one pixel canvas
        queue_pixel(pack_pixel(8'hff, 8'h00, 8'hff, ALPHA_OPAQUE, 8'h00, 8'hff, 8'h00, 8'h00));
        queue_pixel(pack_pixel(8'h12, 8'h34, 8'h56, ALPHA_CLEAR, 8'hab, 8'hcd, 8'hef, 8'h01));
        wait_for_drain();

        // 3x2 sprite hanging off the left and bottom edges, two passes
        program_blit(3, 2, 5, 4, -1, 3);
        for (int i = 0; i < 12; i++) begin
            if (i % 2 == 0)
                queue_pixel(pack_pixel(8'hff, 8'h00, 8'hff, dir_alpha[i],
                                       8'h00, 8'hff, 8'h00, 8'hff));
            else
                queue_pixel(pack_pixel(8'h00, 8'hff, 8'h00, dir_alpha[i],
                                       8'hff, 8'h00, 8'hff, 8'h00));
        end
        wait_for_drain();

        // oversized canvas clamps to the maximum, highest address
        program_blit(1, 1, 32'h7fff, 32'h4000, 16383, 16383);
        queue_pixel(pack_pixel(8'h80, 8'h7f, 8'h01, 8'd128, 8'h7f, 8'h80, 8'hfe, 8'h55));
        wait_for_drain();

        // zero sizes act as one, offsets at the ends of the 16-bit range still clip
        program_blit(0, 0, 20, 20, 32'h8000, 32'h7fff);
        queue_pixel(pack_pixel(8'h11, 8'h22, 8'h33, ALPHA_OPAQUE, 8'h44, 8'h55, 8'h66, 8'h77));
        queue_pixel(pack_pixel(8'hfe, 8'h01, 8'h80, 8'd200, 8'h01, 8'hfe, 8'h7f, 8'haa));
        wait_for_drain();

        // sprite shrunk while the position is past its new bounds
        program_blit(6, 6, 8, 8, 2, 2);
        for (int i = 0; i < 8; i++) queue_pixel(random_pixel());
        wait_for_drain();
        program_blit(2, 1, 8, 8, 2, 2);
        queue_pixel(random_pixel());
        queue_pixel(random_pixel());
        wait_for_drain();

        for (int m = 0; m < 4; m++) begin
            send_idle_pct  = mode_send[m];
            recv_stall_pct = mode_recv[m];
            for (int k = 0; k < 3; k++) begin
                program_blit(random_size(10), random_size(6), random_size(16),
                             random_size(16), random_offset(), random_offset());
                repeat ($urandom_range(85, 55)) queue_pixel(random_pixel());
                wait_for_drain();
            end
        end

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/abc_pkg.sv
rtl/abc_regs.sv
rtl/alpha_blit_compositor_top.sv
bench/tb_alpha_blit_compositor_top.sv
